FILE: design/graph_depth_first_walker_unit_macros.svh
// Assertion macros used by the checker file of the walker unit.
`ifndef GRAPH_DEPTH_FIRST_WALKER_UNIT_MACROS_SVH
`define GRAPH_DEPTH_FIRST_WALKER_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define GDFW_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define GDFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gdfw_pkg.sv
// Package: transaction payload types, op codes and fixed widths of the walker unit.
package gdfw_pkg;

  localparam int unsigned VERTEX_W   = 4;
  localparam int unsigned ORDER_W    = 5;
  localparam int unsigned COUNT_CFG_W = 5;
  localparam logic [COUNT_CFG_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_SET_ARC = 2'd0,
    OP_CLR_ARC = 2'd1,
    OP_WALK    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] target_vertex;
  } in_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [ORDER_W-1:0]  visit_order;
    logic                error;
    logic                last;
  } out_t;

  // Port command of one memory: read and write strobes.
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

endpackage

FILE: design/gdfw_adj_mem.sv
// Adjacency bit matrix: one row per vertex, synchronous read, per-row valid bits.
module gdfw_adj_mem import gdfw_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned VW = $clog2(MAX_VERTICES)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mem_cmd_t                cmd_i,
  input  logic [VW-1:0]           rd_addr_i,
  input  logic [VW-1:0]           wr_addr_i,
  input  logic [MAX_VERTICES-1:0] wr_data_i,
  output logic [MAX_VERTICES-1:0] rd_data_o
);

  logic [MAX_VERTICES-1:0] mem_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_vld_q;
  logic [MAX_VERTICES-1:0] rd_row_q;
  logic                    rd_vld_q;

  // Write a row and register the read row
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  // Track written rows; an unwritten row reads as no arcs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.wr) begin
        row_vld_q[wr_addr_i] <= 1'b1;
      end
      if (cmd_i.rd) begin
        rd_vld_q <= row_vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_row_q : '0;

endmodule

FILE: design/gdfw_stack_mem.sv
// Walk stack: single-port memory of vertex indices with registered read.
module gdfw_stack_mem import gdfw_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW = $clog2(DEPTH),
  parameter int unsigned DW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  mem_cmd_t      cmd_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  // Push writes an entry, pop reads the new top
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[addr_i] <= wr_data_i;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/gdfw_walk_ctrl.sv
// Walk sequencer: arc updates, depth-first scan, visited set and output register.
module gdfw_walk_ctrl import gdfw_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16,
  parameter int unsigned VW = $clog2(MAX_VERTICES),
  parameter int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  in_t                     in_data_i,
  input  logic [CW-1:0]           n_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output out_t                    out_data_o,
  output mem_cmd_t                adj_cmd_o,
  output logic [VW-1:0]           adj_rd_addr_o,
  output logic [VW-1:0]           adj_wr_addr_o,
  output logic [MAX_VERTICES-1:0] adj_wr_data_o,
  input  logic [MAX_VERTICES-1:0] adj_rd_data_i,
  output mem_cmd_t                stk_cmd_o,
  output logic [VW-1:0]           stk_addr_o,
  output logic [VW-1:0]           stk_wr_data_o,
  input  logic [VW-1:0]           stk_rd_data_i
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ARC_WR = 5'b00010,
    S_SCAN   = 5'b00100,
    S_STK    = 5'b01000,
    S_LAST   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [1:0]              op_q, op_d;
  logic [VW-1:0]           src_q, src_d;
  logic [VW-1:0]           dst_q, dst_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           sp_q, sp_d;
  out_t                    pend_q, pend_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_q, out_d;
  logic                    out_load;

  logic                    slot_free;
  logic [MAX_VERTICES-1:0] nmask;
  logic [MAX_VERTICES-1:0] cand;
  logic [VW-1:0]           w_idx;
  logic [CW-1:0]           cnt_inc;
  logic [CW-1:0]           sp_m2;
  logic [MAX_VERTICES-1:0] dst_bit;
  logic                    in_bad;
  logic [VW-1:0]           in_src;

  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_inc   = count_q + CW'(1);
  assign sp_m2     = sp_q - CW'(2);
  assign in_src    = VW'(in_data_i.source_vertex);

  // Mask of vertices in use
  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (32'(i) < 32'(n_i));
    end
  end

  assign cand = adj_rd_data_i & ~visited_q & nmask;

  // Lowest unvisited neighbor of the top vertex
  always_comb begin
    w_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        w_idx = VW'(i);
      end
    end
  end

  always_comb begin
    dst_bit        = '0;
    dst_bit[dst_q] = 1'b1;
  end

  // Reject unused op codes and out-of-range vertices
  assign in_bad = !(in_data_i.op == OP_SET_ARC || in_data_i.op == OP_CLR_ARC ||
                    in_data_i.op == OP_WALK) ||
                  (32'(in_data_i.source_vertex) >= 32'(n_i)) ||
                  ((in_data_i.op != OP_WALK) &&
                   (32'(in_data_i.target_vertex) >= 32'(n_i)));

  // Sequence one transaction at a time
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    src_d         = src_q;
    dst_d         = dst_q;
    visited_d     = visited_q;
    count_d       = count_q;
    sp_d          = sp_q;
    pend_d        = pend_q;
    out_load      = 1'b0;
    out_d         = pend_q;
    in_ready_o    = 1'b0;
    adj_cmd_o     = '0;
    adj_rd_addr_o = src_q;
    adj_wr_addr_o = src_q;
    adj_wr_data_o = (op_q == OP_SET_ARC) ? (adj_rd_data_i | dst_bit)
                                         : (adj_rd_data_i & ~dst_bit);
    stk_cmd_o     = '0;
    stk_addr_o    = sp_q[VW-1:0];
    stk_wr_data_o = w_idx;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d  = in_data_i.op;
          src_d = in_src;
          dst_d = VW'(in_data_i.target_vertex);
          if (in_bad) begin
            pend_d  = '{vertex: '0, visit_order: '0, error: 1'b1, last: 1'b1};
            state_d = S_LAST;
          end else if (in_data_i.op == OP_WALK) begin
            // Visit the start vertex and push it
            visited_d         = '0;
            visited_d[in_src] = 1'b1;
            count_d           = CW'(1);
            sp_d              = CW'(1);
            pend_d            = '{vertex: in_data_i.source_vertex,
                                  visit_order: ORDER_W'(1), error: 1'b0, last: 1'b0};
            stk_cmd_o.wr      = 1'b1;
            stk_addr_o        = '0;
            stk_wr_data_o     = in_src;
            adj_cmd_o.rd      = 1'b1;
            adj_rd_addr_o     = in_src;
            state_d           = S_SCAN;
          end else begin
            pend_d        = '{vertex: '0, visit_order: '0, error: 1'b0, last: 1'b1};
            adj_cmd_o.rd  = 1'b1;
            adj_rd_addr_o = in_src;
            state_d       = S_ARC_WR;
          end
        end
      end

      S_ARC_WR: begin
        // Write back the modified row
        adj_cmd_o.wr = 1'b1;
        state_d      = S_LAST;
      end

      S_SCAN: begin
        if (cand != '0) begin
          // Release the previous visit, push the new vertex, fetch its row
          if (slot_free) begin
            out_load         = 1'b1;
            pend_d           = '{vertex: VERTEX_W'(w_idx), visit_order: ORDER_W'(cnt_inc),
                                 error: 1'b0, last: 1'b0};
            count_d          = cnt_inc;
            visited_d[w_idx] = 1'b1;
            if (32'(sp_q) < MAX_VERTICES) begin
              stk_cmd_o.wr = 1'b1;
              sp_d         = sp_q + CW'(1);
            end
            adj_cmd_o.rd  = 1'b1;
            adj_rd_addr_o = w_idx;
          end
        end else begin
          // Pop; fetch the new top or finish
          sp_d = sp_q - CW'(1);
          if (sp_q == CW'(1)) begin
            state_d = S_LAST;
          end else begin
            stk_cmd_o.rd = 1'b1;
            stk_addr_o   = sp_m2[VW-1:0];
            state_d      = S_STK;
          end
        end
      end

      S_STK: begin
        adj_cmd_o.rd  = 1'b1;
        adj_rd_addr_o = stk_rd_data_i;
        state_d       = S_SCAN;
      end

      S_LAST: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_d.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold a result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      visited_q   <= '0;
      count_q     <= '0;
      sp_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      visited_q   <= visited_d;
      count_q     <= count_d;
      sp_q        <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    pend_q <= pend_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/graph_depth_first_walker_unit.sv
// Top level: depth-first walker over an adjacency bit matrix.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------
//   cfg     | in        | cfg_we_i             | cfg_wdata_i (vertex_count)
//   in      | in        | in_valid_i/in_ready_o | in_data_i (in_t)
//   out     | out       | out_valid_o/out_ready_i | out_data_o (out_t)
//
// One transaction at a time. An error goes straight to its final result, and an arc
// update reads one adjacency row and writes it back. A walk does one row read per
// push and a stack read plus row read per pop.
// Reset clears the matrix through per-row valid bits at once; no clearing pass.
// A full output register stalls the walk at its next visit until it is taken.
module graph_depth_first_walker_unit import gdfw_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_CFG_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_t                    in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_t                   out_data_o
);

  localparam int unsigned VW = $clog2(MAX_VERTICES);
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  logic [COUNT_CFG_W-1:0]  vertex_count_q;
  logic [CW-1:0]           n_eff;
  mem_cmd_t                adj_cmd;
  logic [VW-1:0]           adj_rd_addr;
  logic [VW-1:0]           adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data;
  logic [MAX_VERTICES-1:0] adj_rd_data;
  mem_cmd_t                stk_cmd;
  logic [VW-1:0]           stk_addr;
  logic [VW-1:0]           stk_wr_data;
  logic [VW-1:0]           stk_rd_data;

  // Hold the vertex count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      vertex_count_q <= cfg_wdata_i;
    end
  end

  // Clamp the count to the matrix size
  assign n_eff = (32'(vertex_count_q) > MAX_VERTICES) ? CW'(MAX_VERTICES)
                                                      : CW'(vertex_count_q);

  gdfw_walk_ctrl #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .n_i           (n_eff),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o),
    .adj_cmd_o     (adj_cmd),
    .adj_rd_addr_o (adj_rd_addr),
    .adj_wr_addr_o (adj_wr_addr),
    .adj_wr_data_o (adj_wr_data),
    .adj_rd_data_i (adj_rd_data),
    .stk_cmd_o     (stk_cmd),
    .stk_addr_o    (stk_addr),
    .stk_wr_data_o (stk_wr_data),
    .stk_rd_data_i (stk_rd_data)
  );

  gdfw_adj_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .VW           (VW)
  ) u_adj (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (adj_cmd),
    .rd_addr_i (adj_rd_addr),
    .wr_addr_i (adj_wr_addr),
    .wr_data_i (adj_wr_data),
    .rd_data_o (adj_rd_data)
  );

  gdfw_stack_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (VW),
    .DW    (VW)
  ) u_stk (
    .clk_i     (clk_i),
    .cmd_i     (stk_cmd),
    .addr_i    (stk_addr),
    .wr_data_i (stk_wr_data),
    .rd_data_o (stk_rd_data)
  );

endmodule

FILE: design/gdfw_checker.sv
// Port checker of the walker unit and its bind to the top level.
`include "graph_depth_first_walker_unit_macros.svh"

module gdfw_checker import gdfw_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input out_t out_data_o
);

  // A stalled result holds
  `GDFW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // An error result is a bare final result
  `GDFW_ASSERT_IMPL(a_err_shape, out_valid_o && out_data_o.error, out_data_o.last && out_data_o.vertex == '0 && out_data_o.visit_order == '0, "malformed error result")

  // Acknowledgements and errors are single results
  `GDFW_ASSERT_IMPL(a_single_last, out_valid_o && out_data_o.visit_order == '0, out_data_o.last, "single result without last")

  // An accepted transaction blocks the next one
  `GDFW_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "input taken during a transaction")

  // A walk still in progress takes no new transaction
  `GDFW_ASSERT_IMPL(a_walk_busy, out_valid_o && !out_data_o.last, !in_ready_o, "input ready during a walk")

endmodule

bind graph_depth_first_walker_unit gdfw_checker u_gdfw_checker (.*);

FILE: tb/graph_depth_first_walker_unit_test.sv
// Testbench for the depth-first graph walker: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module graph_depth_first_walker_unit_test;
  import gdfw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned MAX_VERTS = 16;
  localparam int DRAIN_CYCLES = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENTS = 15;
  localparam int SEGMENT_ITEMS = 30;

  localparam out_t ACK_RESULT = '{vertex: '0, visit_order: '0, error: 1'b0, last: 1'b1};
  localparam out_t ERROR_RESULT = '{vertex: '0, visit_order: '0, error: 1'b1, last: 1'b1};

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    in_t                    cmd;
    logic [COUNT_CFG_W-1:0] count;
    logic                   typed;
    out_t                   result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [COUNT_CFG_W-1:0] cfg_wdata_i = COUNT_RESET;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  // Shadow copy of the graph and the vertex count
  logic [MAX_VERTS-1:0] adj_rows [MAX_VERTS];
  logic [COUNT_CFG_W-1:0] count_reg = COUNT_RESET;

  out_t expected_visits[$];
  stim_row_t directed_rows[$];
  int fail_count = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_off_request = 1'b0;

  graph_depth_first_walker_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [COUNT_CFG_W-1:0] live_count();
    return (count_reg > MAX_VERTS) ? COUNT_CFG_W'(MAX_VERTS) : count_reg;
  endfunction

  // Apply one command to the shadow graph and list the results it yields
  function automatic void predict_visits(input in_t cmd, ref out_t res_q[$]);
    logic [COUNT_CFG_W-1:0] n;
    logic [MAX_VERTS-1:0] seen;
    logic [VERTEX_W-1:0] stk_vertex [MAX_VERTS];
    logic [COUNT_CFG_W-1:0] stk_next [MAX_VERTS];
    logic [VERTEX_W-1:0] v;
    int sp;
    int top;
    int w;
    int order;
    bit found;
    out_t res;
    n = live_count();
    if (cmd.op == OP_UNUSED || cmd.source_vertex >= n ||
        (cmd.op != OP_WALK && cmd.target_vertex >= n)) begin
      res_q.push_back(ERROR_RESULT);
      return;
    end
    if (cmd.op == OP_SET_ARC || cmd.op == OP_CLR_ARC) begin
      adj_rows[cmd.source_vertex][cmd.target_vertex] = (cmd.op == OP_SET_ARC);
      res_q.push_back(ACK_RESULT);
      return;
    end
    // Preorder walk with an explicit stack, neighbors scanned low to high
    seen = '0;
    seen[cmd.source_vertex] = 1'b1;
    order = 1;
    res = '{vertex: cmd.source_vertex, visit_order: ORDER_W'(1), error: 1'b0, last: 1'b0};
    res_q.push_back(res);
    stk_vertex[0] = cmd.source_vertex;
    stk_next[0] = '0;
    sp = 1;
    while (sp > 0) begin
      top = sp - 1;
      v = stk_vertex[top];
      w = stk_next[top];
      found = 1'b0;
      while (w < n) begin
        if (adj_rows[v][w] && !seen[w]) begin
          found = 1'b1;
          break;
        end
        w++;
      end
      if (found) begin
        stk_next[top] = COUNT_CFG_W'(w + 1);
        seen[w] = 1'b1;
        order++;
        res = '{vertex: VERTEX_W'(w), visit_order: ORDER_W'(order), error: 1'b0,
                last: 1'b0};
        res_q.push_back(res);
        if (sp < MAX_VERTS) begin
          stk_vertex[sp] = VERTEX_W'(w);
          stk_next[sp] = '0;
          sp++;
        end
      end else begin
        sp--;
      end
    end
    res_q[res_q.size() - 1].last = 1'b1;
  endfunction

  function automatic stim_row_t row_item(logic [1:0] op, logic [VERTEX_W-1:0] src,
                                         logic [VERTEX_W-1:0] dst);
    stim_row_t row;
    row.kind = ROW_ITEM;
    row.cmd = '{op: op, source_vertex: src, target_vertex: dst};
    row.count = '0;
    row.typed = 1'b0;
    row.result = '0;
    return row;
  endfunction

  function automatic stim_row_t row_checked(logic [1:0] op, logic [VERTEX_W-1:0] src,
                                            logic [VERTEX_W-1:0] dst, out_t result);
    stim_row_t row;
    row = row_item(op, src, dst);
    row.typed = 1'b1;
    row.result = result;
    return row;
  endfunction

  function automatic stim_row_t row_cfg(logic [COUNT_CFG_W-1:0] count);
    stim_row_t row;
    row = row_item(OP_SET_ARC, '0, '0);
    row.kind = ROW_CFG;
    row.count = count;
    return row;
  endfunction

  // A walk over a vertex with no reachable neighbor
  function automatic out_t visit_alone(logic [VERTEX_W-1:0] v);
    return '{vertex: v, visit_order: ORDER_W'(1), error: 1'b0, last: 1'b1};
  endfunction

  // Offer one transaction, then queue what it should produce
  task automatic send_item(input in_t cmd, input logic typed, input out_t typed_result);
    int gap;
    out_t predicted[$];
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_visits(cmd, predicted);
    if (typed) begin
      expected_visits.push_back(typed_result);
    end else begin
      foreach (predicted[i]) expected_visits.push_back(predicted[i]);
    end
  endtask

  // Drain the block, then write the vertex count
  task automatic write_vertex_count(input logic [COUNT_CFG_W-1:0] count);
    in_valid_i <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    count_reg = count;
  endtask

  // Stimulus: directed table, then random segments
  initial begin
    in_t cmd;
    logic [COUNT_CFG_W-1:0] n;
    int pick;
    foreach (adj_rows[i]) adj_rows[i] = '0;

    directed_rows.push_back(row_checked(OP_WALK, 0, 0, visit_alone(0)));
    directed_rows.push_back(row_checked(OP_WALK, 15, 15, visit_alone(15)));
    directed_rows.push_back(row_checked(OP_SET_ARC, 0, 15, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_SET_ARC, 15, 0, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_SET_ARC, 0, 3, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_SET_ARC, 3, 1, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_SET_ARC, 0, 1, ACK_RESULT));
    // setting an existing arc and clearing an absent one are plain acks
    directed_rows.push_back(row_checked(OP_SET_ARC, 0, 1, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_CLR_ARC, 2, 5, ACK_RESULT));
    directed_rows.push_back(row_item(OP_WALK, 0, 9));
    directed_rows.push_back(row_checked(OP_CLR_ARC, 0, 15, ACK_RESULT));
    directed_rows.push_back(row_item(OP_WALK, 15, 0));
    directed_rows.push_back(row_checked(OP_UNUSED, 0, 0, ERROR_RESULT));
    directed_rows.push_back(row_checked(OP_UNUSED, 15, 15, ERROR_RESULT));
    // shrunk count: indices above it fail, stored arcs beyond it stay hidden
    directed_rows.push_back(row_cfg(4));
    directed_rows.push_back(row_checked(OP_SET_ARC, 2, 7, ERROR_RESULT));
    directed_rows.push_back(row_checked(OP_SET_ARC, 7, 0, ERROR_RESULT));
    directed_rows.push_back(row_checked(OP_WALK, 5, 0, ERROR_RESULT));
    directed_rows.push_back(row_item(OP_WALK, 0, 0));
    directed_rows.push_back(row_item(OP_WALK, 3, 15));
    // no vertices at all
    directed_rows.push_back(row_cfg(0));
    directed_rows.push_back(row_checked(OP_WALK, 0, 0, ERROR_RESULT));
    directed_rows.push_back(row_checked(OP_CLR_ARC, 0, 0, ERROR_RESULT));
    // oversized count behaves as the full sixteen
    directed_rows.push_back(row_cfg(31));
    directed_rows.push_back(row_checked(OP_SET_ARC, 15, 15, ACK_RESULT));
    directed_rows.push_back(row_item(OP_WALK, 15, 0));
    directed_rows.push_back(row_cfg(1));
    directed_rows.push_back(row_checked(OP_SET_ARC, 0, 0, ACK_RESULT));
    directed_rows.push_back(row_checked(OP_WALK, 0, 0, visit_alone(0)));
    directed_rows.push_back(row_cfg(16));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_vertex_count(directed_rows[i].count);
      end else begin
        send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].result);
      end
    end

    // Random segments, each under its own vertex count and idling style
    hold_off_request = 1'b1;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg > 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) write_vertex_count(COUNT_CFG_W'(MAX_VERTS));
        else if (pick < 8) write_vertex_count(COUNT_CFG_W'($urandom_range(2, 15)));
        else if (pick == 8) write_vertex_count(COUNT_CFG_W'($urandom_range(17, 31)));
        else write_vertex_count(COUNT_CFG_W'($urandom_range(0, 1)));
      end
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < SEGMENT_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) cmd.op = OP_SET_ARC;
        else if (pick < 68) cmd.op = OP_CLR_ARC;
        else if (pick < 95) cmd.op = OP_WALK;
        else cmd.op = OP_UNUSED;
        n = live_count();
        // mostly legal indices, now and then any index at all
        if (n > 0 && $urandom_range(0, 9) != 0) begin
          cmd.source_vertex = VERTEX_W'($urandom_range(0, n - 1));
          cmd.target_vertex = VERTEX_W'($urandom_range(0, n - 1));
        end else begin
          cmd.source_vertex = VERTEX_W'($urandom_range(0, 15));
          cmd.target_vertex = VERTEX_W'($urandom_range(0, 15));
        end
        send_item(cmd, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (expected_visits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off to back the block up
  initial begin
    int stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait();
      if (hold_off_request) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare each result transaction with the oldest expectation; watch for a hang
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_visits.size() == 0) begin
          $error("result with none expected: vertex %0d order %0d error %0b last %0b",
                 out_data_o.vertex, out_data_o.visit_order, out_data_o.error,
                 out_data_o.last);
          fail_count++;
        end else begin
          want = expected_visits.pop_front();
          if (out_data_o.vertex !== want.vertex) begin
            $error("vertex: expected %0d, got %0d", want.vertex, out_data_o.vertex);
            fail_count++;
          end
          if (out_data_o.visit_order !== want.visit_order) begin
            $error("visit_order: expected %0d, got %0d", want.visit_order,
                   out_data_o.visit_order);
            fail_count++;
          end
          if (out_data_o.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, out_data_o.error);
            fail_count++;
          end
          if (out_data_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data_o.last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
